// ----- hdl/gcm_pkg.sv -----
package gcm_pkg;

  // Table geometry and datapath width.
  localparam int MAX_DENOMS = 8;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(MAX_DENOMS + 1);
  localparam int IDX_W      = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;

  // Restoring divider produces one quotient bit per cycle.
  localparam int DIV_STEPS  = DATA_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Operation codes carried by an item.
  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_LOAD     = 2'd1,
    KIND_WITHDRAW = 2'd2
  } kind_e;

  // Write port of the denomination memory.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

endpackage

// ----- hdl/gcm_denom_ram.sv -----
module gcm_denom_ram import gcm_pkg::*; (
  input  logic              clk_i,
  input  ram_wr_t           wr_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [MAX_DENOMS];
  logic [DATA_W-1:0] rd_data_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/gcm_divider.sv -----
module gcm_divider import gcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o,
  output logic [DATA_W-1:0] remainder_o
);

  logic              run_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] divisor_q;

  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;
  logic              fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    shifted = {rem_q, quo_q[DATA_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor_q};
    fits    = ~diff[DATA_W+1];
  end

  // Control of the iteration count and the done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- hdl/greedy_change_maker.sv -----
// A clear empties the table and leaves the block idle. A load reads each table entry
// from the tail and moves smaller ones down; an empty table takes the load at once.
// A withdraw gives one result per table entry (one for an empty table), each after a
// memory read, plus a run of the one-bit-per-cycle divider if the amount covers it.
// Results cannot be stalled; the strobe is high for one cycle per result.
// Reset empties the table at once; memory contents stay undefined and are never read.
module greedy_change_maker import gcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              result_valid_o,
  output logic [DATA_W-1:0] note_value_o,
  output logic [DATA_W-1:0] note_count_o,
  output logic [DATA_W-1:0] left_over_o,
  output logic              last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_HEAD,
    ST_WD_RD,
    ST_WD_CHK,
    ST_WD_DIV
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  k_q;
  logic [IDX_W-1:0]  i_q;
  logic [DATA_W-1:0] ins_val_q;
  logic [DATA_W-1:0] amount_q;
  logic [DATA_W-1:0] denom_q;

  logic              valid_q;
  logic [DATA_W-1:0] note_value_q;
  logic [DATA_W-1:0] note_count_q;
  logic [DATA_W-1:0] left_over_q;
  logic              last_q;

  ram_wr_t           ram_wr;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] div_rem;

  logic              accept;
  logic              load_ok;
  logic [CNT_W-1:0]  cnt_m1;
  logic              last_hit;

  gcm_denom_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  gcm_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (amount_q),
    .divisor_i   (rd_data),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Decode of the incoming item and of the table walk position.
  always_comb begin
    accept   = start && (state_q == ST_IDLE);
    load_ok  = (value_i != '0) && (count_q < CNT_W'(MAX_DENOMS));
    cnt_m1   = count_q - 1'b1;
    last_hit = (CNT_W'(i_q) == cnt_m1);
  end

  // Memory addressing: the insert walks down from the tail, the withdraw walks up.
  always_comb begin
    ram_wr    = '0;
    rd_addr   = (state_q == ST_INS_RD) ? k_q : i_q;
    div_start = (state_q == ST_WD_CHK) && (amount_q >= rd_data);
    case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == KIND_LOAD) && load_ok && (count_q == '0)) begin
          ram_wr = '{en: 1'b1, addr: '0, data: value_i};
        end
      end
      ST_INS_CMP: begin
        // A smaller entry moves one place down; otherwise the new value lands below it.
        ram_wr.en   = 1'b1;
        ram_wr.addr = k_q + 1'b1;
        ram_wr.data = (rd_data < ins_val_q) ? rd_data : ins_val_q;
      end
      ST_INS_HEAD: begin
        ram_wr = '{en: 1'b1, addr: '0, data: ins_val_q};
      end
      default: ;
    endcase
  end

  // Sequencer with the registered result outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      k_q          <= '0;
      i_q          <= '0;
      ins_val_q    <= '0;
      amount_q     <= '0;
      denom_q      <= '0;
      valid_q      <= 1'b0;
      note_value_q <= '0;
      note_count_q <= '0;
      left_over_q  <= '0;
      last_q       <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (kind_i)
              KIND_CLEAR: begin
                count_q <= '0;
              end
              KIND_LOAD: begin
                if (load_ok) begin
                  ins_val_q <= value_i;
                  if (count_q == '0) begin
                    count_q <= count_q + 1'b1;
                  end else begin
                    k_q     <= cnt_m1[IDX_W-1:0];
                    state_q <= ST_INS_RD;
                  end
                end
              end
              KIND_WITHDRAW: begin
                if (count_q == '0) begin
                  // Empty table: report the whole amount as unpaid.
                  valid_q      <= 1'b1;
                  note_value_q <= '0;
                  note_count_q <= '0;
                  left_over_q  <= value_i;
                  last_q       <= 1'b1;
                end else begin
                  amount_q <= value_i;
                  i_q      <= '0;
                  state_q  <= ST_WD_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_INS_RD: begin
          state_q <= ST_INS_CMP;
        end
        ST_INS_CMP: begin
          if (rd_data < ins_val_q) begin
            if (k_q == '0) begin
              state_q <= ST_INS_HEAD;
            end else begin
              k_q     <= k_q - 1'b1;
              state_q <= ST_INS_RD;
            end
          end else begin
            count_q <= count_q + 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_INS_HEAD: begin
          count_q <= count_q + 1'b1;
          state_q <= ST_IDLE;
        end
        ST_WD_RD: begin
          state_q <= ST_WD_CHK;
        end
        ST_WD_CHK: begin
          denom_q <= rd_data;
          if (amount_q >= rd_data) begin
            state_q <= ST_WD_DIV;
          end else begin
            // Amount below this denomination: nothing paid, amount carries on.
            valid_q      <= 1'b1;
            note_value_q <= rd_data;
            note_count_q <= '0;
            left_over_q  <= amount_q;
            last_q       <= last_hit;
            if (last_hit) begin
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_WD_RD;
            end
          end
        end
        ST_WD_DIV: begin
          if (div_done) begin
            valid_q      <= 1'b1;
            note_value_q <= denom_q;
            note_count_q <= div_quo;
            left_over_q  <= div_rem;
            last_q       <= last_hit;
            amount_q     <= div_rem;
            if (last_hit) begin
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_WD_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign note_value_o   = note_value_q;
  assign note_count_o   = note_count_q;
  assign left_over_o    = left_over_q;
  assign last_o         = last_q;

endmodule

// ----- hdl/gcm_checker.sv -----
module gcm_checker import gcm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [1:0]        kind_i,
  input logic [DATA_W-1:0] value_i,
  input logic              result_valid_o,
  input logic [DATA_W-1:0] note_value_o,
  input logic [DATA_W-1:0] note_count_o,
  input logic [DATA_W-1:0] left_over_o,
  input logic              last_o
);

  // A clear or load item never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i != KIND_WITHDRAW)) |=> !result_valid_o)
    else $error("result after a clear or load item");

  // A withdraw item either reports at once or keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_WITHDRAW)) |=> (result_valid_o || busy))
    else $error("withdraw item dropped");

  // Once the block goes idle, the result shown must be the final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !busy) |-> last_o)
    else $error("block idle before the final result");

  // Results within one withdraw are separated by at least the memory read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> !result_valid_o)
    else $error("results back to back within a withdraw");

  // The block only becomes busy after taking an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without an accepted item");

endmodule

bind greedy_change_maker gcm_checker u_gcm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .kind_i         (kind_i),
  .value_i        (value_i),
  .result_valid_o (result_valid_o),
  .note_value_o   (note_value_o),
  .note_count_o   (note_count_o),
  .left_over_o    (left_over_o),
  .last_o         (last_o)
);

// ----- dv/greedy_change_maker_checker.sv -----
// Watches the item and result channels of the change maker, predicts every payout
// from a private copy of the denomination table and compares it with what comes out.
module greedy_change_maker_checker import gcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        kind_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic              result_valid_i,
  input  logic [DATA_W-1:0] note_value_i,
  input  logic [DATA_W-1:0] note_count_i,
  input  logic [DATA_W-1:0] left_over_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] note_value;
    logic [DATA_W-1:0] note_count;
    logic [DATA_W-1:0] left_over;
    logic              last;
  } payout_t;

  // Predicted payouts in the order the block must produce them.
  payout_t payout_q[$];

  // Private copy of the table, kept in descending order.
  logic [DATA_W-1:0] denoms[MAX_DENOMS];
  int unsigned       held;

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
               $time, name, want, want, got, got);
      fail_count_o = fail_count_o + 1;
    end
  endtask

  // Inserts one denomination after all entries that are not smaller.
  task automatic insert_denom(input logic [DATA_W-1:0] v);
    int unsigned pos;
    int unsigned k;
    if (v == '0 || held >= MAX_DENOMS) return;
    pos = 0;
    while (pos < held && denoms[pos] >= v) pos++;
    for (k = held; k > pos; k--) denoms[k] = denoms[k-1];
    denoms[pos] = v;
    held = held + 1;
  endtask

  // Greedy walk over the table: one payout per entry, remainder carried on.
  task automatic predict_withdraw(input logic [DATA_W-1:0] amount);
    payout_t           want;
    logic [DATA_W-1:0] amt;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] cnt;
    int unsigned       i;
    amt = amount;
    if (held == 0) begin
      want.note_value = '0;
      want.note_count = '0;
      want.left_over  = amt;
      want.last       = 1'b1;
      payout_q.push_back(want);
      return;
    end
    for (i = 0; i < held; i++) begin
      d   = denoms[i];
      cnt = '0;
      if (d != '0 && amt >= d) begin
        cnt = amt / d;
        amt = amt % d;
      end
      want.note_value = d;
      want.note_count = cnt;
      want.left_over  = amt;
      want.last       = (i + 1 == held);
      payout_q.push_back(want);
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    held         = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    payout_t want;
    if (!rst_ni) begin
      held = 0;
      payout_q.delete();
      pending_o = 0;
    end else begin
      // Results belong to older items, so they are matched before a new item is taken.
      if (result_valid_i) begin
        if (payout_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0d count %0d left %0d last %0d",
                   $time, note_value_i, note_count_i, left_over_i, last_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = payout_q.pop_front();
          check_field("note_value", want.note_value, note_value_i);
          check_field("note_count", want.note_count, note_count_i);
          check_field("left_over", want.left_over, left_over_i);
          check_field("last", {31'd0, want.last}, {31'd0, last_i});
        end
      end

      // Accepted item updates the table or queues its payouts.
      if (start_i && !busy_i) begin
        case (kind_i)
          KIND_CLEAR:    held = 0;
          KIND_LOAD:     insert_denom(value_i);
          KIND_WITHDRAW: predict_withdraw(value_i);
          default: ;
        endcase
      end
      pending_o = payout_q.size();
    end
  end

endmodule

// ----- dv/greedy_change_maker_tb.sv -----
// Drives items into the change maker with random gaps and gives the verdict.
module greedy_change_maker_tb;
  import gcm_pkg::*;

  // Kind code that the block must ignore.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Cycles allowed after the last payout for the block to go quiet.
  localparam int DRAIN_CYCLES = 400;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        kind_i;
  logic [DATA_W-1:0] value_i;
  logic              result_valid_o;
  logic [DATA_W-1:0] note_value_o;
  logic [DATA_W-1:0] note_count_o;
  logic [DATA_W-1:0] left_over_o;
  logic              last_o;
  int                fail_count;
  int                pending;

  bit                quiet;
  int                rand_items;

  greedy_change_maker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .note_value_o   (note_value_o),
    .note_count_o   (note_count_o),
    .left_over_o    (left_over_o),
    .last_o         (last_o)
  );

  greedy_change_maker_checker u_payout_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .result_valid_i (result_valid_o),
    .note_value_i   (note_value_o),
    .note_count_i   (note_count_o),
    .left_over_i    (left_over_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Presents one item at a falling edge and holds it until the block takes it.
  task automatic send_item(input logic [1:0] kind, input logic [DATA_W-1:0] value);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start   = 1'b1;
    kind_i  = kind;
    value_i = value;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Denominations from small coins up to the full word.
  function automatic logic [DATA_W-1:0] pick_denom();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 10);
      1:       return $urandom_range(1, 1000);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 5);
      3:       return 32'd1 << $urandom_range(0, 31);
      4:       return $urandom_range(1, 100000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_amount();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 100);
      1:       return $urandom_range(0, 100000);
      2:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n_loads;
    int n_draws;
    start      = 1'b0;
    kind_i     = KIND_CLEAR;
    value_i    = '0;
    quiet      = 1'b0;
    rand_items = 0;
    rst_ni     = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, zero load, duplicates, full table, clear, unused kind.
    send_item(KIND_WITHDRAW, 32'hFFFF_FFFF);
    send_item(KIND_WITHDRAW, 32'd0);
    send_item(KIND_LOAD, 32'd0);
    send_item(KIND_WITHDRAW, 32'd12345);
    send_item(KIND_LOAD, 32'd100);
    send_item(KIND_LOAD, 32'hFFFF_FFFF);
    send_item(KIND_LOAD, 32'd1);
    send_item(KIND_LOAD, 32'd100);
    send_item(KIND_LOAD, 32'd50);
    send_item(KIND_LOAD, 32'd7);
    send_item(KIND_LOAD, 32'h8000_0000);
    send_item(KIND_LOAD, 32'd20);
    send_item(KIND_LOAD, 32'd3);
    send_item(KIND_WITHDRAW, 32'hFFFF_FFFF);
    send_item(KIND_WITHDRAW, 32'd0);
    send_item(KIND_WITHDRAW, 32'd99);
    send_item(KIND_UNUSED, 32'hFFFF_FFFF);
    send_item(KIND_WITHDRAW, 32'd177);
    send_item(KIND_CLEAR, 32'hFFFF_FFFF);
    send_item(KIND_WITHDRAW, 32'd42);
    send_item(KIND_LOAD, 32'hFFFF_FFFF);
    send_item(KIND_WITHDRAW, 32'hFFFF_FFFE);
    send_item(KIND_WITHDRAW, 32'hFFFF_FFFF);
    send_item(KIND_CLEAR, 32'd0);

    // Random: mostly fill-then-withdraw sequences, some loose noise items.
    while (rand_items < 86) begin
      if (rand_items > 66) quiet = 1'b1;
      if ($urandom_range(0, 4) != 0) begin
        send_item(KIND_CLEAR, $urandom());
        n_loads = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        repeat (n_loads) send_item(KIND_LOAD, pick_denom());
        n_draws = $urandom_range(1, 4);
        repeat (n_draws) send_item(KIND_WITHDRAW, pick_amount());
        rand_items = rand_items + 1 + n_loads + n_draws;
      end else begin
        kind_i = 2'($urandom_range(0, 3));
        if (kind_i == KIND_UNUSED) begin
          send_item(KIND_UNUSED, $urandom());
        end else begin
          send_item(kind_i, (kind_i == KIND_LOAD) ? pick_denom() : pick_amount());
          rand_items = rand_items + 1;
        end
      end
    end
    start = 1'b0;

    // Drain the outstanding payouts, then let the block settle.
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/gcm_pkg.sv
hdl/gcm_denom_ram.sv
hdl/gcm_divider.sv
hdl/greedy_change_maker.sv
hdl/gcm_checker.sv
dv/greedy_change_maker_checker.sv
dv/greedy_change_maker_tb.sv
